### hdl/gray_contrast_gauss_blur_3x3_top_macros.svh
// Assertion macros for the gray contrast blur block.
// Used by the top level; depends on nothing else.
`ifndef GRAY_CONTRAST_GAUSS_BLUR_3X3_TOP_MACROS_SVH
`define GRAY_CONTRAST_GAUSS_BLUR_3X3_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCGB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcgb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GCGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcgb assertion failed");

`endif

### hdl/gcgb_pkg.sv
// Shared constants, types and functions of the gray contrast blur block.
// Depends on nothing; used by the interfaces and the top level.
package gcgb_pkg;

   localparam int unsigned MaxWidth   = 2048;
   localparam int unsigned LineAw     = $clog2(MaxWidth);
   localparam int unsigned ColW       = LineAw;
   localparam int unsigned RowW       = 13;
   localparam int unsigned ImgWidthW  = 12;
   localparam int unsigned ImgHeightW = 13;
   localparam int unsigned CsrDataW   = 13;
   localparam int unsigned EffWidthW  =
      ($clog2(MaxWidth + 1) > ImgWidthW) ? $clog2(MaxWidth + 1) : ImgWidthW;

   localparam int unsigned PixW      = 8;
   localparam int unsigned PixelRowW = 12;
   localparam int unsigned PixelColW = 11;
   localparam int unsigned GraySumW  = 13;
   localparam int unsigned SumW      = 10;
   localparam int unsigned WeightW   = 13;

   localparam logic [ImgWidthW-1:0]  WidthReset  = 12'd640;
   localparam logic [ImgHeightW-1:0] HeightReset = 13'd480;

   localparam logic [GraySumW-1:0] CoefRed   = 13'd11;
   localparam logic [GraySumW-1:0] CoefGreen = 13'd16;
   localparam logic [GraySumW-1:0] CoefBlue  = 13'd5;
   localparam logic [PixW-1:0]     GrayLow   = 8'd50;
   localparam logic [PixW-1:0]     GrayHigh  = 8'd200;
   localparam logic [PixW-1:0]     GrayBlack = 8'd0;
   localparam logic [PixW-1:0]     GrayWhite = 8'd255;

   localparam logic [WeightW-1:0] WEdge   = 13'd7812;
   localparam logic [WeightW-1:0] WCorner = 13'd6056;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   function automatic logic [PixW-1:0] weigh(input logic [WeightW-1:0] weight,
                                             input logic [SumW-1:0] sum);
      logic [WeightW+SumW-1:0] prod;
      prod = (WeightW + SumW)'(weight) * (WeightW + SumW)'(sum);
      return PixW'(prod[WeightW+SumW-1:16]);
   endfunction

endpackage

### hdl/gcgb_if.sv
// Pixel and result channel interfaces with valid/ready handshake.
// Depends on gcgb_pkg for the field widths.
interface gcgb_req_if import gcgb_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            frame_start;
   logic [PixW-1:0] red;
   logic [PixW-1:0] green;
   logic [PixW-1:0] blue;

   modport source (output valid, frame_start, red, green, blue, input ready);
   modport sink (input valid, frame_start, red, green, blue, output ready);
endinterface

interface gcgb_rsp_if import gcgb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PixelRowW-1:0] pixel_row;
   logic [PixelColW-1:0] pixel_col;
   logic [PixW-1:0]      blurred_value;

   modport source (output valid, pixel_row, pixel_col, blurred_value, input ready);
   modport sink (input valid, pixel_row, pixel_col, blurred_value, output ready);
endinterface

### hdl/gcgb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low; a read of the entry being
// written returns the old contents. Depends on nothing.
module gcgb_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/gray_contrast_gauss_blur_3x3_top.sv
// Gray conversion, contrast stretch and 3x3 Gaussian blur over a raster stream.
// Depends on gcgb_pkg, gcgb_if, gcgb_ram and the assertion macro header.
//
// Pixels enter on req_chan as RGB beats in raster order; frame_start marks the
// first pixel of a frame and clears the row and column counters. Each pixel is
// turned to gray, clipped to black below 50 and to white above 200, and stored
// in a line memory that holds the two previous rows side by side in one word.
// For every pixel at row r >= 2 and column c >= 2 inside the image width, a
// beat leaves on rsp_chan with the blurred value of the pixel at (r-1, c-1).
// Border pixels give no beat, and pixels past image_height are dropped.
// The block takes one pixel per cycle unless the pipeline stalls; the line
// memory is read once and written once per cycle, with forwarding when
// consecutive pixels hit the same column. A result passes through stages 1,
// 2 and 3 to the output register. When the receiver stalls, the three internal
// stages still fill, so input beats keep being taken until they are all
// occupied. Reset clears the counters, the window and all stage valid bits
// and loads width 640 and height 480, not the line memory. The block does not
// enforce that the user writes width and height through csr_* only while idle.
`include "gray_contrast_gauss_blur_3x3_top_macros.svh"

module gray_contrast_gauss_blur_3x3_top import gcgb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   gcgb_req_if.sink            req_chan,
   gcgb_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  csr_index_type       csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam logic [EffWidthW-1:0] MaxWidthEff = EffWidthW'(MaxWidth);

   logic [ImgWidthW-1:0]  width_ff;
   logic [ImgHeightW-1:0] height_ff;
   logic [ColW-1:0]       col_ff;
   logic [ColW-1:0]       col_in;
   logic [RowW-1:0]       row_ff;
   logic [RowW-1:0]       row_in;

   logic [ColW-1:0]      cur_col;
   logic [RowW-1:0]      cur_row;
   logic [EffWidthW-1:0] eff_width;
   logic                 skip_pixel;
   logic                 take;
   logic                 row_end;
   logic                 emit;
   logic [GraySumW-1:0]  gray_sum;
   logic [PixW-1:0]      gray_raw;
   logic [PixW-1:0]      gray;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_emit_ff;
   logic [ColW-1:0]      s1_col_ff;
   logic [RowW-1:0]      s1_row_ff;
   logic [PixW-1:0]      s1_gray_ff;
   logic                 s1_fwd_ff;
   logic [PixW-1:0]      s1_fwd_top_ff;
   logic [PixW-1:0]      s1_fwd_mid_ff;
   logic                 s1_go;
   logic [PixW-1:0]      s1_top;
   logic [PixW-1:0]      s1_mid;
   logic [2*PixW-1:0]    ram_rd_data;

   logic [PixW-1:0]      win_ff [6];

   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic                 s2_go;
   logic                 s2_ready;
   logic [SumW-1:0]      s2_sum_a_ff;
   logic [SumW-1:0]      s2_sum_b_ff;
   logic [SumW-1:0]      s2_sum_c_ff;
   logic [SumW-1:0]      s2_sum_d_ff;
   logic [PixelRowW-1:0] s2_row_ff;
   logic [PixelColW-1:0] s2_col_ff;

   logic                 s3_valid_ff;
   logic                 s3_valid_in;
   logic                 s3_go;
   logic                 s3_ready;
   logic [PixW-1:0]      s3_term_a_ff;
   logic [PixW-1:0]      s3_term_b_ff;
   logic [PixW-1:0]      s3_term_c_ff;
   logic [PixW-1:0]      s3_term_d_ff;
   logic [PixelRowW-1:0] s3_row_ff;
   logic [PixelColW-1:0] s3_col_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 out_ready;
   logic [PixW:0]        out_total;
   logic [PixW-1:0]      out_value_ff;
   logic [PixelRowW-1:0] out_row_ff;
   logic [PixelColW-1:0] out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[ImgWidthW-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ImgHeightW-1:0];
         endcase
      end
   end

   assign cur_col    = req_chan.frame_start ? '0 : col_ff;
   assign cur_row    = req_chan.frame_start ? '0 : row_ff;
   assign eff_width  = (EffWidthW'(width_ff) > MaxWidthEff) ? MaxWidthEff
                                                              : EffWidthW'(width_ff);
   assign skip_pixel = (ImgHeightW'(cur_row) >= height_ff);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign take       = req_chan.valid && req_chan.ready && !skip_pixel;
   assign row_end    = ((EffWidthW + 1)'(cur_col) + 1'b1) >= (EffWidthW + 1)'(eff_width);
   assign emit       = (cur_row >= RowW'(2)) && (cur_col >= ColW'(2)) &&
                       (EffWidthW'(cur_col) < eff_width);

   assign gray_sum = GraySumW'(req_chan.red) * CoefRed +
                     GraySumW'(req_chan.green) * CoefGreen +
                     GraySumW'(req_chan.blue) * CoefBlue;
   assign gray_raw = gray_sum[GraySumW-1:5];

   always_comb begin
      priority if (gray_raw < GrayLow) begin
         gray = GrayBlack;
      end else if (gray_raw > GrayHigh) begin
         gray = GrayWhite;
      end else begin
         gray = gray_raw;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_chan.valid && req_chan.ready) begin
         col_in = cur_col;
         row_in = cur_row;
         if (!skip_pixel) begin
            if (row_end) begin
               col_in = '0;
               row_in = cur_row + 1'b1;
            end else begin
               col_in = cur_col + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   gcgb_ram #(
      .Width (2 * PixW),
      .Depth (MaxWidth)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_mid, s1_gray_ff}),
      .rd_en   (take),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   assign s1_go       = s1_valid_ff && (!s1_emit_ff || s2_ready);
   assign s1_valid_in = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign s1_top      = s1_fwd_ff ? s1_fwd_top_ff : ram_rd_data[2*PixW-1:PixW];
   assign s1_mid      = s1_fwd_ff ? s1_fwd_mid_ff : ram_rd_data[PixW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_emit_ff    <= emit;
         s1_col_ff     <= cur_col;
         s1_row_ff     <= cur_row;
         s1_gray_ff    <= gray;
         s1_fwd_ff     <= s1_go && (s1_col_ff == cur_col);
         s1_fwd_top_ff <= s1_mid;
         s1_fwd_mid_ff <= s1_gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= s1_top;
         win_ff[1] <= s1_mid;
         win_ff[2] <= s1_gray_ff;
      end
   end

   assign s2_go       = s2_valid_ff && s3_ready;
   assign s2_ready    = !s2_valid_ff || s2_go;
   assign s2_valid_in = (s1_go && s1_emit_ff) ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         s2_sum_a_ff <= SumW'(win_ff[1]) + SumW'(win_ff[0]) + SumW'(win_ff[2]);
         s2_sum_b_ff <= SumW'(win_ff[4]) + SumW'(s1_mid);
         s2_sum_c_ff <= SumW'(s1_gray_ff) + SumW'(win_ff[5]);
         s2_sum_d_ff <= SumW'(s1_top) + SumW'(win_ff[3]);
         s2_row_ff   <= PixelRowW'(s1_row_ff - 1'b1);
         s2_col_ff   <= PixelColW'(s1_col_ff - 1'b1);
      end
   end

   assign s3_go       = s3_valid_ff && out_ready;
   assign s3_ready    = !s3_valid_ff || s3_go;
   assign s3_valid_in = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_term_a_ff <= weigh(WEdge, s2_sum_a_ff);
         s3_term_b_ff <= weigh(WEdge, s2_sum_b_ff);
         s3_term_c_ff <= weigh(WCorner, s2_sum_c_ff);
         s3_term_d_ff <= weigh(WCorner, s2_sum_d_ff);
         s3_row_ff    <= s2_row_ff;
         s3_col_ff    <= s2_col_ff;
      end
   end

   assign out_ready    = !out_valid_ff || rsp_chan.ready;
   assign out_valid_in = s3_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   assign out_total    = (PixW + 1)'(s3_term_a_ff) + (PixW + 1)'(s3_term_b_ff) +
                         (PixW + 1)'(s3_term_c_ff) + (PixW + 1)'(s3_term_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go) begin
         out_value_ff <= out_total[PixW-1:0];
         out_row_ff   <= s3_row_ff;
         out_col_ff   <= s3_col_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_row     = out_row_ff;
   assign rsp_chan.pixel_col     = out_col_ff;
   assign rsp_chan.blurred_value = out_value_ff;

   `GCGB_ASSERT_NEXT(a_skipped_pixel_not_staged, clock, reset,
      req_chan.valid && req_chan.ready && skip_pixel, !s1_valid_ff)
   `GCGB_ASSERT_NEXT(a_stalled_stage_holds, clock, reset,
      s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_col_ff) && $stable(s1_gray_ff))
   `GCGB_ASSERT_SAME(a_result_col_interior, clock, reset,
      out_valid_ff, out_col_ff != '0)

endmodule

### tb/tb.sv
// Self-checking testbench for gray_contrast_gauss_blur_3x3_top: drives RGB pixel beats,
// predicts each blurred interior pixel and compares every result beat against it.
// Depends on gcgb_pkg, gcgb_if and the RTL of the block; reads no files.
module tb import gcgb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QuietLimit   = 2000;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned EdgeWeight   = 7812;
   localparam int unsigned CornerWeight = 6056;
   localparam int unsigned ContrastLow  = 50;
   localparam int unsigned ContrastHigh = 200;

   localparam logic [11:0][23:0] ContrastProbes = {
      24'h000000, 24'h313131, 24'h323232, 24'h333333,
      24'hC7C7C7, 24'hC8C8C8, 24'hC9C9C9, 24'hFFFFFF,
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF
   };

   typedef struct packed {
      logic [PixelRowW-1:0] row;
      logic [PixelColW-1:0] col;
      logic [PixW-1:0]      value;
   } blur_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   gcgb_req_if req_if();
   gcgb_rsp_if rsp_if();

   gray_contrast_gauss_blur_3x3_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   logic [ImgWidthW-1:0]  width_reg  = WidthReset;
   logic [ImgHeightW-1:0] height_reg = HeightReset;
   logic [PixW-1:0]       older_line [MaxWidth];
   logic [PixW-1:0]       newer_line [MaxWidth];
   int unsigned           top_win [2] = '{0, 0};
   int unsigned           mid_win [2] = '{0, 0};
   int unsigned           bot_win [2] = '{0, 0};
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   blur_result_type expected_blurs [$];
   blur_result_type oldest_blur;

   int unsigned send_gap_pct   = 0;
   int unsigned out_stall_pct  = 0;
   int unsigned hold_request   = 0;
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned pixels_sent    = 0;
   int unsigned blurs_checked  = 0;
   int unsigned error_count    = 0;

   function automatic int unsigned apply_weight(input int unsigned weight,
                                                input int unsigned sum);
      return (weight * sum) >> 16;
   endfunction

   function automatic void predict_blur(input bit first, input logic [PixW-1:0] red,
                                        input logic [PixW-1:0] green,
                                        input logic [PixW-1:0] blue);
      int unsigned     eff_w, r, c, gray, top_px, mid_px, bot_px, blur;
      blur_result_type res;
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (row_pos >= height_reg) return;
      eff_w = (width_reg > MaxWidth) ? MaxWidth : width_reg;
      r = row_pos;
      c = col_pos;
      gray = (11 * red + 16 * green + 5 * blue) >> 5;
      if (gray < ContrastLow) gray = 0;
      if (gray > ContrastHigh) gray = 255;
      bot_px = gray;
      if (c < MaxWidth) begin
         top_px = older_line[c];
         mid_px = newer_line[c];
         older_line[c] = PixW'(mid_px);
         newer_line[c] = PixW'(gray);
      end else begin
         top_px = 0;
         mid_px = 0;
      end
      if (r >= 2 && c >= 2 && c < eff_w) begin
         blur = apply_weight(EdgeWeight, mid_win[0] + top_win[0] + bot_win[0]);
         blur += apply_weight(EdgeWeight, mid_win[1] + mid_px);
         blur += apply_weight(CornerWeight, bot_px + bot_win[1]);
         blur += apply_weight(CornerWeight, top_px + top_win[1]);
         res.row   = PixelRowW'(r - 1);
         res.col   = PixelColW'(c - 1);
         res.value = PixW'(blur);
         expected_blurs.push_back(res);
      end
      top_win[1] = top_win[0];
      mid_win[1] = mid_win[0];
      bot_win[1] = bot_win[0];
      top_win[0] = top_px;
      mid_win[0] = mid_px;
      bot_win[0] = bot_px;
      if (c + 1 >= eff_w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic send_pixel(input bit first, input logic [PixW-1:0] red,
                             input logic [PixW-1:0] green, input logic [PixW-1:0] blue);
      while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.frame_start <= first;
      req_if.red         <= red;
      req_if.green       <= green;
      req_if.blue        <= blue;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_blur(first, red, green, blue);
      pixels_sent++;
   endtask

   task automatic send_random_pixel(input bit first);
      send_pixel(first, PixW'($urandom), PixW'($urandom), PixW'($urandom));
   endtask

   task automatic wait_drain;
      req_if.valid <= 1'b0;
      while (expected_blurs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      if (idx == CSR_IMAGE_WIDTH) begin
         csr_wdata <= {1'($urandom), ImgWidthW'(value)};
         width_reg = ImgWidthW'(value);
      end else begin
         csr_wdata  <= CsrDataW'(value);
         height_reg = ImgHeightW'(value);
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_frame(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_random_pixel(i == 0);
   endtask

   task automatic test_contrast_levels;
      int unsigned i;
      write_csr(CSR_IMAGE_WIDTH, 4);
      write_csr(CSR_IMAGE_HEIGHT, 3);
      for (i = 0; i < 12; i++)
         send_pixel(i == 0, ContrastProbes[i][23:16], ContrastProbes[i][15:8],
                    ContrastProbes[i][7:0]);
      for (i = 0; i < 3; i++) send_random_pixel(1'b0);
      write_csr(CSR_IMAGE_WIDTH, 3);
      for (i = 0; i < 9; i++) send_pixel(i == 0, 8'hFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_degenerate_sizes;
      int unsigned w;
      write_csr(CSR_IMAGE_HEIGHT, 5);
      for (w = 0; w < 3; w++) begin
         write_csr(CSR_IMAGE_WIDTH, w);
         send_frame(8);
      end
      write_csr(CSR_IMAGE_WIDTH, 4);
      write_csr(CSR_IMAGE_HEIGHT, 0);
      send_frame(8);
      write_csr(CSR_IMAGE_WIDTH, 3);
      write_csr(CSR_IMAGE_HEIGHT, 3);
      send_frame(9);
   endtask

   task automatic test_random_frames(input int unsigned item_goal);
      int unsigned sent_here, w, h, n, extra, i;
      bit          broken;
      sent_here = 0;
      while (sent_here < item_goal) begin
         w = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 17) : $urandom_range(16, 3);
         h = $urandom_range(7, 3);
         if (w != width_reg) write_csr(CSR_IMAGE_WIDTH, w);
         if (h != height_reg) write_csr(CSR_IMAGE_HEIGHT, h);
         broken = ($urandom_range(4, 0) == 0);
         n      = broken ? $urandom_range(w * h - 1, 1) : w * h;
         extra  = (!broken && $urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0;
         for (i = 0; i < n + extra; i++)
            send_random_pixel(i == 0 || (broken && $urandom_range(31, 0) == 0));
         sent_here += n;
      end
   endtask

   task automatic test_backpressure;
      int unsigned saved_gap;
      saved_gap = send_gap_pct;
      send_gap_pct = 0;
      write_csr(CSR_IMAGE_WIDTH, 8);
      write_csr(CSR_IMAGE_HEIGHT, 6);
      hold_request = 64;
      send_frame(48);
      wait_drain();
      send_frame(48);
      send_gap_pct = saved_gap;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_blurs.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d value %0d, expected none",
                     $time, rsp_if.pixel_row, rsp_if.pixel_col, rsp_if.blurred_value);
            error_count++;
         end else begin
            oldest_blur = expected_blurs.pop_front();
            blurs_checked++;
            if (rsp_if.pixel_row !== oldest_blur.row) begin
               $display("%0t: pixel_row expected %0d, actual %0d",
                        $time, oldest_blur.row, rsp_if.pixel_row);
               error_count++;
            end
            if (rsp_if.pixel_col !== oldest_blur.col) begin
               $display("%0t: pixel_col expected %0d, actual %0d",
                        $time, oldest_blur.col, rsp_if.pixel_col);
               error_count++;
            end
            if (rsp_if.blurred_value !== oldest_blur.value) begin
               $display("%0t: blurred_value expected %0d, actual %0d at row %0d col %0d",
                        $time, oldest_blur.value, rsp_if.blurred_value,
                        oldest_blur.row, oldest_blur.col);
               error_count++;
            end
         end
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset === 1'b1) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99, 0) >= out_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no beat moved for %0d cycles, %0d results still expected",
                     $time, quiet_cycles, expected_blurs.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_IMAGE_WIDTH;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.frame_start <= 1'b0;
      req_if.red         <= '0;
      req_if.green       <= '0;
      req_if.blue        <= '0;
      send_gap_pct  = 26;
      out_stall_pct = 49;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_contrast_levels();
      test_degenerate_sizes();
      test_random_frames(420);
      send_gap_pct  = 49;
      out_stall_pct = 26;
      test_random_frames(420);
      test_backpressure();
      send_gap_pct  = 0;
      out_stall_pct = 0;
      test_random_frames(410);
      wait_drain();

      $display("Sent %0d pixels and checked %0d blurred results over widths 0 to 80,",
               pixels_sent, blurs_checked);
      $display("heights 0 to 7, frame restarts and a long output hold-off.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
